// ===== src/tkdb_pkg.sv =====
// Shared types and codes for the two-key press/release debouncer.
package tkdb_pkg;

    // Request codes carried by an input word
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_WAKE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Key event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_KEY1 = 2'd1;
    localparam logic [1:0] EV_KEY2 = 2'd2;

    // Debounce window after reset, in ticks
    localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

    // One input word
    typedef struct packed {
        logic [1:0] req_type;
        logic       sw1_level;
        logic       sw2_level;
    } t_item;

    // One result word
    typedef struct packed {
        logic [1:0] event_code;
        logic       wake_armed;
        logic [1:0] scan_phase;
    } t_result;

endpackage

// ===== src/tkdb_fsm.sv =====
// Debounce state machine: holds the key state and computes one result per step.
module tkdb_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tkdb_pkg::t_item     i_item,
    input  logic [7:0]          i_debounce_ticks,
    output tkdb_pkg::t_result   o_result
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRESS  = 2'd1,
        PH_HELD   = 2'd2,
        PH_RELCHK = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [1:0] r_cand, n_cand;
    logic [1:0] r_pend, n_pend;
    logic       r_wake, n_wake;
    logic [1:0] ev;

    logic       k1, k2, any;
    logic [1:0] lone;
    logic [7:0] tick_inc;
    logic       win_end;

    // Pin decode: keys are active low
    assign k1       = ~i_item.sw1_level;
    assign k2       = ~i_item.sw2_level;
    assign any      = k1 | k2;
    assign lone     = (k1 && !k2) ? tkdb_pkg::EV_KEY1 :
                      (k2 && !k1) ? tkdb_pkg::EV_KEY2 : tkdb_pkg::EV_NONE;
    assign tick_inc = r_tick + 8'd1;
    // a window of zero ends on the first tick, same as one
    assign win_end  = (tick_inc >= i_debounce_ticks);

    // Next state for the word being applied
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_cand  = r_cand;
        n_pend  = r_pend;
        n_wake  = r_wake;
        ev      = tkdb_pkg::EV_NONE;
        case (i_item.req_type)
            tkdb_pkg::REQ_TICK: begin
                case (r_phase)
                    PH_PRESS: begin
                        n_tick = tick_inc;
                        if (win_end) begin
                            n_tick = 8'd0;
                            n_cand = lone;
                            if (!any) begin
                                n_phase = PH_IDLE;
                                n_wake  = 1'b1;
                            end else begin
                                n_phase = PH_HELD;
                            end
                        end
                    end
                    PH_HELD: begin
                        // both keys down cancels the candidate
                        if (any && lone == tkdb_pkg::EV_NONE) begin
                            n_cand = tkdb_pkg::EV_NONE;
                        end
                        if (!any) begin
                            n_phase = PH_RELCHK;
                            n_tick  = 8'd0;
                        end
                    end
                    PH_RELCHK: begin
                        if (any) begin
                            n_phase = PH_HELD;
                            n_tick  = 8'd0;
                        end else if (win_end) begin
                            n_tick  = 8'd0;
                            n_pend  = r_cand;
                            n_cand  = tkdb_pkg::EV_NONE;
                            n_phase = PH_IDLE;
                            n_wake  = 1'b1;
                        end else begin
                            n_tick = tick_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tkdb_pkg::REQ_WAKE: begin
                if (r_wake) begin
                    n_wake = 1'b0;
                    if (r_phase == PH_IDLE) begin
                        n_phase = PH_PRESS;
                        n_tick  = 8'd0;
                        n_cand  = tkdb_pkg::EV_NONE;
                    end
                end
            end
            tkdb_pkg::REQ_READ: begin
                ev     = r_pend;
                n_pend = tkdb_pkg::EV_NONE;
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the word is applied
    assign o_result.event_code = ev;
    assign o_result.wake_armed = n_wake;
    assign o_result.scan_phase = n_phase;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_cand  <= tkdb_pkg::EV_NONE;
            r_pend  <= tkdb_pkg::EV_NONE;
            r_wake  <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_cand  <= n_cand;
            r_pend  <= n_pend;
            r_wake  <= n_wake;
        end
    end

`ifndef NO_ASSERTIONS
    // wake is armed exactly while the machine sits in idle
    a_wake_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wake == (r_phase == PH_IDLE))
        else $error("wake arm out of step with idle phase");

    // the counter is clear whenever no window is running
    a_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_HELD) |-> r_tick == 8'd0)
        else $error("tick counter not clear outside a window");

    // a read consumes the pending event
    a_read_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.req_type == tkdb_pkg::REQ_READ)
        |=> r_pend == tkdb_pkg::EV_NONE)
        else $error("pending event survived a read");

    // event registers never hold the unused code
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand != 2'd3 && r_pend != 2'd3)
        else $error("illegal key event code");
`endif

endmodule

// ===== src/two_key_press_release_debouncer_top.sv =====
// Top level of the two-key press/release debouncer with its word handshake.
// Each input word (tick, edge wake or read) lands in an input register; the
// state machine then applies it and the result word is captured in the output
// register, so a new word is accepted every clock while the output word is taken.
// The two registers act as a short pipeline; the input stalls when the output
// word is not taken and the input register is full.
// The debounce window register is written through its own port, ready always,
// and resets to 20 ticks.
module two_key_press_release_debouncer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic       i_sw1_level,
    input  logic       i_sw2_level,
    // result words
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_code,
    output logic       o_wake_armed,
    output logic [1:0] o_scan_phase,
    // debounce window register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic              r_in_valid;
    tkdb_pkg::t_item   r_in;
    logic              r_out_valid;
    tkdb_pkg::t_result r_out;
    logic [7:0]        r_debounce;

    logic              out_ready;
    logic              in_ready;
    logic              step;
    tkdb_pkg::t_result result;

    // Pipeline flow control
    assign out_ready = !r_out_valid || !i_stall;
    assign step      = r_in_valid && out_ready;
    assign in_ready  = !r_in_valid || out_ready;
    assign o_stall   = !in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in.req_type  <= i_req_type;
            r_in.sw1_level <= i_sw1_level;
            r_in.sw2_level <= i_sw2_level;
        end
    end

    // Debounce window register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= tkdb_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce <= i_cfg_data;
        end
    end

    tkdb_fsm u_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (r_in),
        .i_debounce_ticks (r_debounce),
        .o_result         (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_out.event_code;
    assign o_wake_armed = r_out.wake_armed;
    assign o_scan_phase = r_out.scan_phase;

endmodule

// ===== verif/two_key_press_release_debouncer_top_tb.sv =====
// Self-checking testbench for the two-key debouncer: scored against an in-bench model of the scan.
module two_key_press_release_debouncer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF      = 6;
    localparam int PIPE_LATENCY  = 2;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int WORK_TARGET   = 1400;
    localparam int LONG_HOLD     = 80;
    localparam int CYCLE_LIMIT   = 600000;

    // Scan phases as reported on o_scan_phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_req_type;
    logic       i_sw1_level;
    logic       i_sw2_level;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_event_code;
    logic       o_wake_armed;
    logic [1:0] o_scan_phase;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    // Debouncer state as the scoreboard sees it
    t_phase     m_phase;
    logic [7:0] m_count;
    logic [7:0] m_window;
    logic [1:0] m_cand;
    logic [1:0] m_pending;
    logic       m_wake;

    tkdb_pkg::t_result key_report_q[$];
    tkdb_pkg::t_result report_seen;
    tkdb_pkg::t_result report_want;

    int  errors;
    int  words_sent;
    int  work_done;
    int  reports_checked;
    int  windows_tried;
    int  long_hold_cycles;
    int  cycles;
    bit  sender_gaps_on;
    bit  receiver_stalls_on;

    two_key_press_release_debouncer_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_sw1_level  (i_sw1_level),
        .i_sw2_level  (i_sw2_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_code (o_event_code),
        .o_wake_armed (o_wake_armed),
        .o_scan_phase (o_scan_phase),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Run limit
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // Random idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Apply one word to the scan state and return the report it produces
    function automatic tkdb_pkg::t_result predict_key_report(input logic [1:0] req,
                                                             input logic s1,
                                                             input logic s2);
        logic              k1;
        logic              k2;
        logic              any_key;
        logic [1:0]        lone;
        tkdb_pkg::t_result r;
        k1 = !s1;
        k2 = !s2;
        any_key = k1 || k2;
        lone = (k1 && !k2) ? tkdb_pkg::EV_KEY1 :
               ((k2 && !k1) ? tkdb_pkg::EV_KEY2 : tkdb_pkg::EV_NONE);
        r.event_code = tkdb_pkg::EV_NONE;
        case (req)
            tkdb_pkg::REQ_TICK: begin
                case (m_phase)
                    PH_PRESS: begin
                        m_count = m_count + 8'd1;
                        if (m_count >= m_window) begin
                            m_count = 8'd0;
                            m_cand = lone;
                            if (!any_key) begin
                                m_phase = PH_IDLE;
                                m_wake = 1'b1;
                            end else begin
                                m_phase = PH_HELD;
                            end
                        end
                    end
                    PH_HELD: begin
                        // second key down while held drops the candidate
                        if (any_key && lone == tkdb_pkg::EV_NONE)
                            m_cand = tkdb_pkg::EV_NONE;
                        if (!any_key) begin
                            m_phase = PH_RELEASE;
                            m_count = 8'd0;
                        end
                    end
                    PH_RELEASE: begin
                        m_count = m_count + 8'd1;
                        if (any_key) begin
                            m_phase = PH_HELD;
                            m_count = 8'd0;
                        end else if (m_count >= m_window) begin
                            m_count = 8'd0;
                            m_pending = m_cand;
                            m_cand = tkdb_pkg::EV_NONE;
                            m_phase = PH_IDLE;
                            m_wake = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            tkdb_pkg::REQ_WAKE: begin
                if (m_wake) begin
                    m_wake = 1'b0;
                    if (m_phase == PH_IDLE) begin
                        m_phase = PH_PRESS;
                        m_count = 8'd0;
                        m_cand = tkdb_pkg::EV_NONE;
                    end
                end
            end
            tkdb_pkg::REQ_READ: begin
                r.event_code = m_pending;
                m_pending = tkdb_pkg::EV_NONE;
            end
            default: ;
        endcase
        r.wake_armed = m_wake;
        r.scan_phase = m_phase;
        return r;
    endfunction

    // Send one word; returns once the block has taken it
    task automatic send_word(input logic [1:0] req, input logic s1, input logic s2);
        int          gap;
        logic [14:0] state_was;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_sw1_level <= s1;
        i_sw2_level <= s2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        state_was = {m_phase, m_count, m_cand, m_pending, m_wake};
        key_report_q.push_back(predict_key_report(req, s1, s2));
        words_sent++;
        if (req == tkdb_pkg::REQ_READ ||
            state_was != {m_phase, m_count, m_cand, m_pending, m_wake})
            work_done++;
    endtask

    task automatic send_tick(input logic [1:0] keys);
        send_word(tkdb_pkg::REQ_TICK, keys[1], keys[0]);
    endtask

    task automatic send_noise();
        send_word(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
    endtask

    // Stop sending and wait for every outstanding report
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (key_report_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the debounce window register while the block is quiet
    task automatic write_window(input logic [7:0] w);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_window = w;
        windows_tried++;
    endtask

    // Reads, ticks and unknown requests straight out of reset
    task automatic test_idle_requests();
        send_word(tkdb_pkg::REQ_READ, 1'b1, 1'b1);
        send_tick(2'b00);
        send_word(REQ_UNUSED, 1'b1, 1'b1);
        send_word(REQ_UNUSED, 1'b0, 1'b0);
    endtask

    // Key one: press, hold, clean release, read back
    task automatic test_key_one();
        write_window(8'd1);
        send_word(tkdb_pkg::REQ_WAKE, 1'b1, 1'b1);
        send_word(tkdb_pkg::REQ_WAKE, 1'b0, 1'b0);   // already disarmed
        send_tick(2'b01);
        send_tick(2'b11);
        send_tick(2'b11);
        send_word(tkdb_pkg::REQ_READ, 1'b0, 1'b1);
    endtask

    // Key two with a cancel by the other key and a bouncing release
    task automatic test_key_two_cancel();
        send_word(tkdb_pkg::REQ_WAKE, 1'b1, 1'b0);
        send_tick(2'b10);
        send_tick(2'b00);
        send_tick(2'b11);
        send_tick(2'b10);
        send_tick(2'b11);
        send_tick(2'b11);
        send_word(tkdb_pkg::REQ_READ, 1'b1, 1'b1);
    endtask

    // Zero window, no key at window end, unread event overwritten by an empty release
    task automatic test_zero_window();
        write_window(8'd0);
        send_word(tkdb_pkg::REQ_WAKE, 1'b1, 1'b1);
        send_tick(2'b11);
        send_word(tkdb_pkg::REQ_WAKE, 1'b0, 1'b1);
        send_tick(2'b10);
        send_tick(2'b11);
        send_tick(2'b11);
        send_word(tkdb_pkg::REQ_WAKE, 1'b0, 1'b0);
        send_tick(2'b00);
        send_tick(2'b11);
        send_tick(2'b11);
        send_word(tkdb_pkg::REQ_READ, 1'b1, 1'b1);
    endtask

    // Receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_output_backpressure();
        bit gaps_were;
        gaps_were = sender_gaps_on;
        sender_gaps_on = 1'b0;
        long_hold_cycles = LONG_HOLD;
        repeat (16) send_noise();
        sender_gaps_on = gaps_were;
        wait_quiet();
    endtask

    // One press/release cycle with random keys, bounce and noise
    task automatic run_press_cycle();
        int         win;
        int         roll;
        logic [1:0] keys;
        win = (m_window == 8'd0) ? 1 : int'(m_window);
        if ($urandom_range(0, 99) < 15)
            send_noise();
        send_word(tkdb_pkg::REQ_WAKE, 1'($urandom), 1'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 42)
            keys = 2'b01;
        else if (roll < 84)
            keys = 2'b10;
        else if (roll < 93)
            keys = 2'b00;
        else
            keys = 2'b11;
        // press window, with the odd bounced sample
        repeat (win) begin
            if ($urandom_range(0, 99) < 8)
                send_tick(2'($urandom));
            else
                send_tick(keys);
        end
        // held, sometimes with the other key joining
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 99) < 10)
                send_tick(2'b00);
            else
                send_tick(keys);
        end
        // release, sometimes cut short by a bounce
        if (win < 50 && $urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(0, win - 1)) send_tick(2'b11);
            send_tick(keys);
        end
        // first idle sample leaves held, then a full window
        repeat (win + 1) send_tick(2'b11);
        if ($urandom_range(0, 99) < 70)
            send_word(tkdb_pkg::REQ_READ, 1'($urandom), 1'($urandom));
    endtask

    // Random traffic over several window settings, the widest one once
    task automatic test_random_traffic();
        bit did_widest;
        did_widest = 1'b0;
        while (words_sent < WORK_TARGET) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            if (!did_widest && words_sent > WORK_TARGET / 2) begin
                did_widest = 1'b1;
                write_window(8'd255);
                run_press_cycle();
            end else begin
                if ($urandom_range(0, 9) == 0)
                    write_window(8'($urandom_range(7, 12)));
                else
                    write_window(8'($urandom_range(1, 6)));
                repeat (6) run_press_cycle();
            end
        end
        wait_quiet();
    endtask

    // Receiver: random stalls, plus the long hold when one is requested
    initial begin : result_receiver
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_cycles > 0) begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (receiver_stalls_on && $urandom_range(0, 99) < 20) begin
                hold = pick_gap() + 1;
            end else begin
                hold = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                while (hold > 0) begin
                    @(posedge i_clk);
                    hold--;
                end
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Check each report word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            report_seen.event_code = o_event_code;
            report_seen.wake_armed = o_wake_armed;
            report_seen.scan_phase = o_scan_phase;
            if (key_report_q.size() == 0) begin
                $error("report word with nothing predicted: %p", report_seen);
                errors++;
            end else begin
                report_want = key_report_q.pop_front();
                reports_checked++;
                if (report_seen.event_code !== report_want.event_code) begin
                    $error("event_code expected %0d got %0d",
                           report_want.event_code, report_seen.event_code);
                    errors++;
                end
                if (report_seen.wake_armed !== report_want.wake_armed) begin
                    $error("wake_armed expected %0d got %0d",
                           report_want.wake_armed, report_seen.wake_armed);
                    errors++;
                end
                if (report_seen.scan_phase !== report_want.scan_phase) begin
                    $error("scan_phase expected %0d got %0d",
                           report_want.scan_phase, report_seen.scan_phase);
                    errors++;
                end
            end
        end
    end

    // Test sequence
    initial begin
        errors = 0;
        words_sent = 0;
        work_done = 0;
        reports_checked = 0;
        windows_tried = 0;
        long_hold_cycles = 0;
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b1;
        m_phase = PH_IDLE;
        m_count = 8'd0;
        m_window = tkdb_pkg::DEBOUNCE_RESET;
        m_cand = tkdb_pkg::EV_NONE;
        m_pending = tkdb_pkg::EV_NONE;
        m_wake = 1'b1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req_type  <= tkdb_pkg::REQ_TICK;
        i_sw1_level <= 1'b1;
        i_sw2_level <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_requests();
        test_key_one();
        test_key_two_cancel();
        test_zero_window();
        test_output_backpressure();
        test_random_traffic();

        wait_quiet();
        if (key_report_q.size() != 0) begin
            $error("%0d predicted reports never arrived", key_report_q.size());
            errors++;
        end
        $display("run: %0d words sent, %0d changed the scan or read it, %0d reports checked",
                 words_sent, work_done, reports_checked);
        $display("run: %0d window writes incl. 0, 1 and 255, with idle and stall gaps",
                 windows_tried);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
